@@ src/mps_pkg.sv @@
package mps_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int ELEMENT_BITS = 16;

  localparam int IN_BITS   = 16;
  localparam int PROD_BITS = 64;
  localparam int FULL_BITS = PROD_BITS + ELEMENT_BITS;
  localparam int ADDR_BITS = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_BITS  = $clog2(MAX_ELEMENTS + 1);

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic signed [PROD_BITS-1:0]    prod_t;
  typedef logic [ADDR_BITS-1:0]           addr_t;
  typedef logic [CNT_BITS-1:0]            cnt_t;

  typedef struct packed {
    prod_t product;
    logic  overflow;
  } mul_res_t;

endpackage

@@ src/mps_mul.sv @@
module mps_mul (
  input  logic             clk,
  input  logic             lo_en,
  input  mps_pkg::prod_t   a,
  input  mps_pkg::elem_t   b,
  output mps_pkg::mul_res_t res
);
  import mps_pkg::*;

  // a * b = (a_hi * b) << 32 + (a_lo unsigned * b), low half first;
  // one 33 x 16 multiplier serves both halves
  logic signed [32:0]              half;
  logic signed [ELEMENT_BITS+32:0] part;
  logic signed [FULL_BITS-1:0]     acc;
  logic signed [FULL_BITS-1:0]     full;
  logic [FULL_BITS-PROD_BITS:0]    top_bits;

  assign half = lo_en ? $signed({1'b0, a[31:0]})
                      : $signed({a[PROD_BITS-1], a[PROD_BITS-1:32]});
  assign part = half * b;

  always_ff @(posedge clk) begin
    if (lo_en) begin
      acc <= {{(FULL_BITS-ELEMENT_BITS-33){part[ELEMENT_BITS+32]}}, part};
    end
  end

  assign full     = acc + $signed({part[ELEMENT_BITS+31:0], 32'b0});
  assign top_bits = full[FULL_BITS-1:PROD_BITS-1];

  // product fits in 64 signed bits only if the upper bits are a sign extension
  assign res.product  = full[PROD_BITS-1:0];
  assign res.overflow = !((&top_bits) || !(|top_bits));

endmodule

@@ src/mps_store.sv @@
module mps_store (
  input  logic           clk,
  input  logic           we,
  input  mps_pkg::addr_t waddr,
  input  mps_pkg::elem_t wdata,
  input  logic           re,
  input  mps_pkg::addr_t raddr,
  output mps_pkg::elem_t rdata
);
  import mps_pkg::*;

  elem_t mem [MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/max_product_subarray.sv @@
// channel | handshake            | payload
// in      | in_valid / in_stall  | element_value, is_last
// out     | out_valid / out_stall| max_product, overflowed
//
// Forward element: S_EVAL and S_NEXT for a first element, plus S_UPD on a
// restart after zero, plus S_MUL_LO and S_MUL_HI for the two-pass 64 x 16
// multiply in mps_mul. Backward walk: one store read (S_B_READ, S_B_LOAD)
// per element, then the same states; S_FINISH loads the output register.
// rst is synchronous; it clears the sequencer, element count, overflow flag
// and output valid. A held result does not block loading the next sequence;
// only the final result load waits on out_stall.
module max_product_subarray (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mps_pkg::IN_BITS-1:0]  element_value,
  input  logic                                is_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mps_pkg::PROD_BITS-1:0] max_product,
  output logic                                overflowed
);
  import mps_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EVAL   = 9'b000000010,
    S_MUL_LO = 9'b000000100,
    S_MUL_HI = 9'b000001000,
    S_UPD    = 9'b000010000,
    S_NEXT   = 9'b000100000,
    S_B_READ = 9'b001000000,
    S_B_LOAD = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  state_t   state;
  cnt_t     count;
  addr_t    pos;
  elem_t    e_cur;
  elem_t    rdata;
  prod_t    prod;
  prod_t    best;
  prod_t    fwd_best;
  prod_t    e_ext;
  logic     first;
  logic     last_q;
  logic     backward;
  logic     ovf_seen;
  logic     accept;
  logic     store_we;
  logic     store_re;
  mul_res_t mres;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign store_we = accept && (count < cnt_t'(MAX_ELEMENTS));
  assign store_re = (state == S_B_READ);
  assign e_ext    = PROD_BITS'(e_cur);

  mps_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[ADDR_BITS-1:0]),
    .wdata (element_value[ELEMENT_BITS-1:0]),
    .re    (store_re),
    .raddr (pos),
    .rdata (rdata)
  );

  // one shared multiplier serves both passes
  mps_mul u_mul (
    .clk   (clk),
    .lo_en (state == S_MUL_LO),
    .a     (prod),
    .b     (e_cur),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // a result loaded in S_FINISH takes over valid on its own
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            e_cur    <= element_value[ELEMENT_BITS-1:0];
            last_q   <= is_last;
            backward <= 1'b0;
            if (store_we) begin
              count <= count + cnt_t'(1);
              first <= (count == '0);
              state <= S_EVAL;
            end else if (is_last) begin
              // store full: element ignored, sequence still ends
              state <= S_NEXT;
            end
          end
        end
        S_EVAL: begin
          if (first) begin
            prod  <= e_ext;
            best  <= e_ext;
            state <= S_NEXT;
          end else if (prod == '0) begin
            // restart after a zero; best is still updated
            prod  <= e_ext;
            state <= S_UPD;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod <= mres.product;
          if (mres.overflow) begin
            ovf_seen <= 1'b1;
          end
          state <= S_UPD;
        end
        S_UPD: begin
          if (prod > best) begin
            best <= prod;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (!backward) begin
            if (last_q) begin
              fwd_best <= best;
              pos      <= ADDR_BITS'(count - cnt_t'(1));
              first    <= 1'b1;
              backward <= 1'b1;
              state    <= S_B_READ;
            end else begin
              state <= S_IDLE;
            end
          end else if (pos == '0) begin
            state <= S_FINISH;
          end else begin
            pos   <= pos - addr_t'(1);
            first <= 1'b0;
            state <= S_B_READ;
          end
        end
        S_B_READ: begin
          state <= S_B_LOAD;
        end
        S_B_LOAD: begin
          e_cur <= rdata;
          state <= S_EVAL;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            max_product <= (fwd_best > best) ? fwd_best : best;
            overflowed  <= ovf_seen;
            out_valid   <= 1'b1;
            count       <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/max_product_subarray_test.sv @@
`timescale 1ns / 1ps

module max_product_subarray_test;
  import mps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 360;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [IN_BITS-1:0] value;
    logic               last;
  } elem_item_t;

  typedef struct {
    prod_t product;
    logic  overflow;
  } best_product_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [IN_BITS-1:0]  element_value;
  logic                       is_last;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [PROD_BITS-1:0] max_product;
  logic                       overflowed;

  max_product_subarray i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .max_product   (max_product),
    .overflowed    (overflowed)
  );

  // 12 ns period, low half first so the first rising edge is at 6 ns
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Stimulus and scoreboard state
  elem_item_t    pending_elems[$];
  best_product_t awaited_results[$];
  int            send_idle_pct;
  int            stall_pct;
  bit            elem_taken;

  int elems_sent;
  int sequences_sent;
  int full_store_runs;
  int results_checked;
  int mismatches;
  int cycle_count;

  // Shadow of the block: stored sequence, forward pass, sticky overflow
  elem_t stored_elems[MAX_ELEMENTS];
  int    held_count;
  prod_t fwd_prod;
  prod_t fwd_best;
  logic  ovf_sticky;

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // One step of a running product: restart on zero, else multiply with
  // 64-bit wrap; the best value is updated either way.
  function automatic void extend_run(inout prod_t prod, inout prod_t best, input elem_t e);
    logic signed [127:0] wide;
    if (prod == '0) begin
      prod = prod_t'(e);
    end else begin
      wide = prod * e;
      if (wide[127:63] != {65{wide[63]}}) begin
        ovf_sticky = 1'b1;
      end
      prod = wide[63:0];
    end
    if (prod > best) begin
      best = prod;
    end
  endfunction

  // Fold one accepted element into the shadow; on the last one run the
  // backward walk and queue the expected result.
  function automatic void absorb_element(logic [IN_BITS-1:0] raw, logic last);
    elem_t         e;
    prod_t         back_prod;
    prod_t         back_best;
    best_product_t res;
    e = elem_t'(raw);
    if (held_count < MAX_ELEMENTS) begin
      stored_elems[held_count] = e;
      if (held_count == 0) begin
        fwd_prod = prod_t'(e);
        fwd_best = prod_t'(e);
      end else begin
        extend_run(fwd_prod, fwd_best, e);
      end
      held_count++;
    end
    if (last) begin
      back_prod = prod_t'(stored_elems[held_count-1]);
      back_best = back_prod;
      for (int i = held_count - 2; i >= 0; i--) begin
        extend_run(back_prod, back_best, stored_elems[i]);
      end
      res.product  = (fwd_best > back_best) ? fwd_best : back_best;
      res.overflow = ovf_sticky;
      awaited_results.push_back(res);
      held_count = 0;
    end
  endfunction

  task automatic push_elem(int value, bit last);
    elem_item_t it;
    it.value = value[IN_BITS-1:0];
    it.last  = last;
    pending_elems.push_back(it);
    elems_sent++;
    if (last) begin
      sequences_sent++;
    end
  endtask

  // Mix of zeros, small magnitudes, full-range values and extremes so that
  // sign flips, restarts and wraps all show up.
  function automatic int random_elem();
    case ($urandom_range(9))
      0, 1:    return 0;
      2, 3, 4: return $urandom_range(8) - 4;
      5, 6:    return $urandom_range(65535);
      7:       return $urandom_range(1) ? 32767 : -32768;
      8:       return $urandom_range(1) ? 1 : -1;
      default: return $urandom_range(200) - 100;
    endcase
  endfunction

  task automatic push_random_sequence(int len);
    for (int i = 0; i < len; i++) begin
      push_elem(random_elem(), i == len - 1);
    end
  endtask

  // Driver: inputs change on the falling edge. A stalled item is held as is.
  always @(negedge clk) begin
    elem_item_t it;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || elem_taken) begin
        if (pending_elems.size() > 0 && !roll(send_idle_pct)) begin
          it = pending_elems.pop_front();
          element_value <= it.value;
          is_last       <= it.last;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= roll(stall_pct);
    end
  end

  // Monitor: both handshakes sampled on the rising edge. Input acceptance
  // feeds the shadow model; output items are checked in order.
  always @(posedge clk) begin
    best_product_t want;
    elem_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        elem_taken = 1'b1;
        absorb_element(element_value, is_last);
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result max_product=%0d overflowed=%0b",
                   $time, max_product, overflowed);
        end else begin
          want = awaited_results.pop_front();
          results_checked++;
          if (max_product !== want.product) begin
            mismatches++;
            $display("%0t: max_product mismatch: expected %0d, got %0d",
                     $time, want.product, max_product);
          end
          if (overflowed !== want.overflow) begin
            mismatches++;
            $display("%0t: overflowed mismatch: expected %0b, got %0b",
                     $time, want.overflow, overflowed);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still awaited", $time, awaited_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int phase_start;
    rst           = 1'b1;
    in_valid      = 1'b0;
    out_stall     = 1'b0;
    element_value = '0;
    is_last       = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    elem_taken    = 1'b0;
    held_count    = 0;
    fwd_prod      = '0;
    fwd_best      = '0;
    ovf_sticky    = 1'b0;
    elems_sent      = 0;
    sequences_sent  = 0;
    full_store_runs = 0;
    results_checked = 0;
    mismatches      = 0;
    cycle_count     = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      // idle mix: none, sender-heavy, receiver-heavy, both light
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 25; stall_pct = 25; end
      endcase
      phase_start = elems_sent;

      if (phase == 0) begin
        // single-element sequences at both extremes and zero
        push_elem(-32768, 1);
        push_elem(32767, 1);
        push_elem(0, 1);
        // zeros force restarts, including onto a negative value
        push_elem(0, 0);
        push_elem(-5, 0);
        push_elem(0, 0);
        push_elem(-3, 1);
        // best run lies after a zero and needs two negatives
        push_elem(2, 0);
        push_elem(-3, 0);
        push_elem(0, 0);
        push_elem(-2, 0);
        push_elem(-4, 1);
        // products past 64 bits: overflow flag goes up and stays up
        repeat (4) push_elem(32767, 0);
        push_elem(32767, 1);
        repeat (4) push_elem(-32768, 0);
        push_elem(7, 1);
        // clean sequence after overflow still reports the sticky flag
        push_elem(-1, 0);
        push_elem(4, 1);
      end

      // store full: elements past capacity ignored, last one still ends it
      if (phase == 0 || phase == 3) begin
        push_random_sequence(MAX_ELEMENTS + $urandom_range(1, 6));
        full_store_runs++;
      end

      while (elems_sent - phase_start < PHASE_ITEMS) begin
        push_random_sequence($urandom_range(1, 12));
      end

      while (pending_elems.size() != 0 || in_valid || awaited_results.size() != 0) begin
        @(posedge clk);
      end
    end

    // give any stray output time to show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d elements in %0d sequences (%0d overfilling the store), %0d results checked",
             elems_sent, sequences_sent, full_store_runs, results_checked);
    $display("across four idle/stall mixes, %0d mismatches", mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
